@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// Depends on nothing; take in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under clock and reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication under clock and reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/ole_pkg.sv @@
// Package of the ordered list engine: item types, command, status and cell action codes.
// Depends on nothing; used by every module of the block.
package ole_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int VALUE_W          = 32;
   localparam int OPCODE_W         = 3;
   localparam int STATUS_W         = 2;
   localparam int COUNT_W          = 7;
   localparam int ACTION_W         = 3;

   // Command codes
   localparam logic [OPCODE_W-1:0] OP_APPEND    = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_INS_FRONT = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_INS_BACK  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_INS_AFTER = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_RM_FRONT  = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_RM_BACK   = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_RM_KEY    = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_DUMP      = 3'd7;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_KEY   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

   // Cell actions
   localparam logic [ACTION_W-1:0] ACT_HOLD  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_LEFT  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_RIGHT = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_NEW   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_HEAD  = 3'd4;

   typedef struct packed {
      logic [OPCODE_W-1:0]       opcode;
      logic signed [VALUE_W-1:0] new_value;
      logic signed [VALUE_W-1:0] match_key;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] out_value;
      logic                      last_of_run;
      logic [COUNT_W-1:0]        entry_count;
   } rsp_type;

   typedef struct packed {
      logic [ACTION_W-1:0]       action;
      logic                      compare;
      logic signed [VALUE_W-1:0] new_value;
      logic signed [VALUE_W-1:0] key;
   } cell_ctrl_type;

endpackage

@@ rtl/ordered_list_engine.sv @@
// Top level of the ordered list engine: command sequencer, chain of cells, result register.
// Depends on ole_pkg and ole_cell.
//
//   channel | direction | handshake             | payload
//   req_    | in        | req_valid / req_stall | req_type (opcode, new_value, match_key)
//   rsp_    | out       | rsp_valid / rsp_stall | rsp_type (status, out_value, ...)
//
// An item is taken with its key compare loaded into every cell; the sequencer then
// decides the status and shifts the chain. A dump adds a step for each held entry,
// each rotating the chain by one place and showing the head.
// Reset clears the entry count and the sequencer; cell contents stay as they are.
// A stalled result holds the sequencer; the next item is taken while a result waits.
module ordered_list_engine import ole_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_DUMP = 2'd2;

   logic [1:0]                state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             dump_idx_ff, dump_idx_in;
   logic [OPCODE_W-1:0]       op_ff;
   logic signed [VALUE_W-1:0] new_value_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic signed [VALUE_W-1:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0]       cell_match;
   cell_ctrl_type             cell_ctrl [CAPACITY];

   logic                accept, slot_free, apply, empty, full, found, has_after;
   logic [CAPACITY-1:0] valid_m, last_m, tail_m, match_m, match_dec;
   logic [CAPACITY-1:0] below_m, first_m, after_m;

   logic [STATUS_W-1:0]       status_x;
   logic                      ins_x, rem_x, rot_x, start_dump;
   logic [CAPACITY-1:0]       keep_x, new_x, sel_x;
   logic [CW-1:0]             count_next_x;
   logic signed [VALUE_W-1:0] out_sel;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign apply     = slot_free && ((state_ff == S_EXEC) || (state_ff == S_DUMP));

   // Occupancy masks of the chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_valid
      assign valid_m[i] = (CW'(i) < count_ff);
   end
   assign last_m = valid_m & ~(valid_m >> 1);
   assign tail_m = ((valid_m << 1) | CAPACITY'(1)) & ~valid_m;
   assign empty  = (count_ff == '0);
   assign full   = (count_ff == CW'(CAPACITY));

   // First match: bits below it and its one-hot place from one subtract
   assign match_m   = cell_match & valid_m;
   assign match_dec = match_m - CAPACITY'(1);
   assign below_m   = match_dec & ~match_m;
   assign first_m   = match_m & ~match_dec;
   assign found     = |match_m;
   assign after_m   = valid_m & ~below_m & ~first_m;
   assign has_after = |after_m;

   // Decode the command into status and a shift plan
   always_comb begin
      status_x   = STATUS_DONE;
      ins_x      = 1'b0;
      rem_x      = 1'b0;
      rot_x      = 1'b0;
      start_dump = 1'b0;
      keep_x     = '0;
      new_x      = '0;
      sel_x      = '0;
      if (state_ff == S_DUMP) begin
         rem_x = 1'b1;
         rot_x = 1'b1;
         sel_x = CAPACITY'(1);
      end else begin
         unique case (op_ff)
            OP_APPEND: begin
               if (full) begin
                  status_x = STATUS_FULL;
               end else begin
                  ins_x  = 1'b1;
                  keep_x = valid_m;
                  new_x  = tail_m;
               end
            end
            OP_INS_FRONT: begin
               if (empty) begin
                  status_x = STATUS_EMPTY;
               end else if (full) begin
                  status_x = STATUS_FULL;
               end else begin
                  ins_x = 1'b1;
                  new_x = CAPACITY'(1);
               end
            end
            OP_INS_BACK: begin
               if (empty) begin
                  status_x = STATUS_EMPTY;
               end else if (full) begin
                  status_x = STATUS_FULL;
               end else begin
                  ins_x  = 1'b1;
                  keep_x = valid_m;
                  new_x  = tail_m;
               end
            end
            OP_INS_AFTER: begin
               if (empty) begin
                  status_x = STATUS_EMPTY;
               end else if (!has_after) begin
                  status_x = STATUS_KEY;
               end else if (full) begin
                  status_x = STATUS_FULL;
               end else begin
                  ins_x  = 1'b1;
                  keep_x = below_m | first_m;
                  new_x  = first_m << 1;
               end
            end
            OP_RM_FRONT: begin
               if (empty) begin
                  status_x = STATUS_EMPTY;
               end else begin
                  rem_x = 1'b1;
                  sel_x = CAPACITY'(1);
               end
            end
            OP_RM_BACK: begin
               if (empty) begin
                  status_x = STATUS_EMPTY;
               end else begin
                  rem_x  = 1'b1;
                  keep_x = valid_m & ~last_m;
                  sel_x  = last_m;
               end
            end
            OP_RM_KEY: begin
               if (empty) begin
                  status_x = STATUS_EMPTY;
               end else if (!has_after || first_m[0]) begin
                  status_x = STATUS_KEY;
               end else begin
                  rem_x  = 1'b1;
                  keep_x = below_m;
                  sel_x  = first_m;
               end
            end
            OP_DUMP: begin
               if (empty) begin
                  status_x = STATUS_EMPTY;
               end else begin
                  start_dump = 1'b1;
               end
            end
         endcase
      end
   end

   // Entry count after this step
   always_comb begin
      priority if (ins_x) begin
         count_next_x = count_ff + CW'(1);
      end else if (rem_x && !rot_x) begin
         count_next_x = count_ff - CW'(1);
      end else begin
         count_next_x = count_ff;
      end
   end

   // Read out the selected entry
   always_comb begin
      out_sel = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         out_sel = out_sel | (sel_x[i] ? cell_value[i] : '0);
      end
   end

   // Sequence the item and fill the result register
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dump_idx_in  = dump_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (slot_free) begin
               if (start_dump) begin
                  state_in    = S_DUMP;
                  dump_idx_in = '0;
               end else begin
                  state_in                 = S_IDLE;
                  count_in                 = count_next_x;
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.status       = status_x;
                  rsp_data_in.out_value    = rem_x ? out_sel : '0;
                  rsp_data_in.last_of_run  = 1'b1;
                  rsp_data_in.entry_count  = COUNT_W'(count_next_x);
               end
            end
         end
         S_DUMP: begin
            if (slot_free) begin
               dump_idx_in              = dump_idx_ff + CW'(1);
               rsp_valid_in             = 1'b1;
               rsp_data_in.status       = STATUS_DONE;
               rsp_data_in.out_value    = out_sel;
               rsp_data_in.last_of_run  = (dump_idx_ff == count_ff - CW'(1));
               rsp_data_in.entry_count  = COUNT_W'(count_ff);
               if (dump_idx_ff == count_ff - CW'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the command and the result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff        <= req_data.opcode;
         new_value_ff <= req_data.new_value;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // Row of cells, each fed by its neighbors
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ACTION_W-1:0]       action;
      logic signed [VALUE_W-1:0] left_value, right_value;

      always_comb begin
         action = ACT_HOLD;
         if (apply && ins_x) begin
            priority if (new_x[i]) begin
               action = ACT_NEW;
            end else if (keep_x[i]) begin
               action = ACT_HOLD;
            end else begin
               action = ACT_LEFT;
            end
         end else if (apply && rem_x) begin
            priority if (keep_x[i]) begin
               action = ACT_HOLD;
            end else if (rot_x && last_m[i]) begin
               action = ACT_HEAD;
            end else begin
               action = ACT_RIGHT;
            end
         end
      end

      if (i == 0) begin : g_first
         assign left_value = new_value_ff;
      end else begin : g_mid_l
         assign left_value = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_mid_r
         assign right_value = cell_value[i+1];
      end

      assign cell_ctrl[i].action    = action;
      assign cell_ctrl[i].compare   = accept;
      assign cell_ctrl[i].new_value = new_value_ff;
      assign cell_ctrl[i].key       = req_data.match_key;

      ole_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl[i]),
         .left_value  (left_value),
         .right_value (right_value),
         .head_value  (cell_value[0]),
         .value       (cell_value[i]),
         .match       (cell_match[i])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/ole_cell.sv @@
// One storage cell of the list chain: holds one entry and its key match flag.
// Depends on ole_pkg; instantiated in a row by ordered_list_engine.
module ole_cell import ole_pkg::*; (
   input  logic                      clock,
   input  cell_ctrl_type             ctrl,
   input  logic signed [VALUE_W-1:0] left_value,
   input  logic signed [VALUE_W-1:0] right_value,
   input  logic signed [VALUE_W-1:0] head_value,
   output logic signed [VALUE_W-1:0] value,
   output logic                      match
);

   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      match_ff, match_in;

   // Pick the next entry from a neighbor, the new value or the head
   always_comb begin
      unique case (ctrl.action)
         ACT_LEFT:  value_in = left_value;
         ACT_RIGHT: value_in = right_value;
         ACT_NEW:   value_in = ctrl.new_value;
         ACT_HEAD:  value_in = head_value;
         default:   value_in = value_ff;
      endcase
   end

   // Capture the key compare when an item enters
   assign match_in = ctrl.compare ? (value_ff == ctrl.key) : match_ff;

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      match_ff <= match_in;
   end

   assign value = value_ff;
   assign match = match_ff;

endmodule

@@ rtl/ole_checker.sv @@
// Port-level checker of the ordered list engine, attached by bind.
// Depends on ole_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ole_checker import ole_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A stalled result item holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // One item at a time: the input stalls right after an item is taken
   `ASSERT_NEXT(a_one_item, clock, reset, req_valid && !req_stall, req_stall)

   // A refused command reports no value
   `ASSERT_IMPLIES(a_refused_zero, clock, reset, rsp_valid && rsp_data.status != STATUS_DONE,
                   rsp_data.out_value == '0)

   // A full store refusal shows a full count, and the count never passes capacity
   `ASSERT_IMPLIES(a_full_count, clock, reset, rsp_valid && rsp_data.status == STATUS_FULL,
                   rsp_data.entry_count == COUNT_W'(CAPACITY))
   `ASSERT_IMPLIES(a_count_cap, clock, reset, rsp_valid,
                   rsp_data.entry_count <= COUNT_W'(CAPACITY))

endmodule

bind ordered_list_engine ole_checker #(.CAPACITY(CAPACITY)) u_ole_checker (.*);

@@ dv/tb_ordered_list_engine.sv @@
// Self-checking testbench of ordered_list_engine: directed table, full-store corner, random run.
// Depends on ole_pkg and the RTL of the block; results are checked against a shadow list model.
module tb_ordered_list_engine;
   import ole_pkg::*;

   localparam int CAPACITY       = CAPACITY_DEFAULT;
   localparam int RANDOM_ITEMS   = 64;
   localparam int LONG_HOLD      = 200;
   localparam int END_WAIT_LIMIT = 200000;
   localparam int TAIL_CYCLES    = 2 * CAPACITY + 8;
   localparam int TIMEOUT_CYCLES = 2000000;
   localparam int PRINT_LIMIT    = 100;

   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      req_type cmd;
      logic    typed;
      rsp_type want;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // shadow copy of the list and the results still owed by the block
   logic signed [VALUE_W-1:0] shadow_list[$];
   rsp_type                   step_results[$];
   rsp_type                   pending_results[$];
   stim_row_type              stim_rows[$];
   int                        fill_at;

   int  mismatch_count;
   int  items_accepted;
   int  results_checked;
   int  dumps_sent;
   int  refusals;
   int  deepest;
   bit  quiet_mode;
   bit  long_hold_req;

   ordered_list_engine DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
   endtask

   function automatic int find_first(input logic signed [VALUE_W-1:0] key);
      for (int i = 0; i < shadow_list.size(); i++)
         if (shadow_list[i] == key) return i;
      return shadow_list.size();
   endfunction

   // Apply one command to the shadow list and collect the results it causes
   task automatic advance_shadow_list(input req_type cmd);
      int      depth;
      int      pos;
      rsp_type r;
      depth = shadow_list.size();
      pos = find_first(cmd.match_key);
      step_results.delete();
      r = '0;
      r.status = STATUS_DONE;
      r.last_of_run = 1'b1;
      case (cmd.opcode)
         OP_APPEND: begin
            if (depth >= CAPACITY) r.status = STATUS_FULL;
            else shadow_list.push_back(cmd.new_value);
         end
         OP_INS_FRONT, OP_INS_BACK: begin
            if (depth == 0) r.status = STATUS_EMPTY;
            else if (depth >= CAPACITY) r.status = STATUS_FULL;
            else if (cmd.opcode == OP_INS_FRONT) shadow_list.push_front(cmd.new_value);
            else shadow_list.push_back(cmd.new_value);
         end
         OP_INS_AFTER: begin
            if (depth == 0) r.status = STATUS_EMPTY;
            else if (pos + 1 >= depth) r.status = STATUS_KEY;
            else if (depth >= CAPACITY) r.status = STATUS_FULL;
            else shadow_list.insert(pos + 1, cmd.new_value);
         end
         OP_RM_FRONT: begin
            if (depth == 0) r.status = STATUS_EMPTY;
            else r.out_value = shadow_list.pop_front();
         end
         OP_RM_BACK: begin
            if (depth == 0) r.status = STATUS_EMPTY;
            else r.out_value = shadow_list.pop_back();
         end
         OP_RM_KEY: begin
            if (depth == 0) r.status = STATUS_EMPTY;
            else if (pos == 0 || pos + 1 >= depth) r.status = STATUS_KEY;
            else begin
               r.out_value = shadow_list[pos];
               shadow_list.delete(pos);
            end
         end
         default: begin
            if (depth == 0) r.status = STATUS_EMPTY;
         end
      endcase
      if (cmd.opcode == OP_DUMP && depth != 0) begin
         // stream every entry, last flag on the back one
         foreach (shadow_list[i]) begin
            r.out_value = shadow_list[i];
            r.last_of_run = (i == depth - 1);
            r.entry_count = COUNT_W'(depth);
            step_results.push_back(r);
         end
      end else begin
         r.entry_count = COUNT_W'(shadow_list.size());
         step_results.push_back(r);
         if (r.status != STATUS_DONE) refusals++;
      end
      if (shadow_list.size() > deepest) deepest = shadow_list.size();
   endtask

   // Offer one item, wait for it to be taken, then book its results
   task automatic issue_item(input req_type cmd, input logic typed, input rsp_type want);
      int unsigned gap;
      gap = quiet_mode ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= cmd;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      items_accepted++;
      if (cmd.opcode == OP_DUMP) dumps_sent++;
      advance_shadow_list(cmd);
      if (typed) pending_results.push_back(want);
      else foreach (step_results[i]) pending_results.push_back(step_results[i]);
      @(negedge clock);
   endtask

   // Hold the input idle until the block owes nothing
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic req_type make_cmd(input logic [OPCODE_W-1:0] op,
                                        input logic signed [VALUE_W-1:0] nv,
                                        input logic signed [VALUE_W-1:0] key);
      req_type c;
      c.opcode = op;
      c.new_value = nv;
      c.match_key = key;
      return c;
   endfunction

   function automatic stim_row_type plain_row(input logic [OPCODE_W-1:0] op,
                                              input logic signed [VALUE_W-1:0] nv,
                                              input logic signed [VALUE_W-1:0] key);
      stim_row_type row;
      row.cmd = make_cmd(op, nv, key);
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   function automatic stim_row_type typed_row(input logic [OPCODE_W-1:0] op,
                                              input logic signed [VALUE_W-1:0] nv,
                                              input logic signed [VALUE_W-1:0] key,
                                              input logic [STATUS_W-1:0] st,
                                              input logic signed [VALUE_W-1:0] val,
                                              input int count);
      stim_row_type row;
      row = plain_row(op, nv, key);
      row.typed = 1'b1;
      row.want.status = st;
      row.want.out_value = val;
      row.want.last_of_run = 1'b1;
      row.want.entry_count = COUNT_W'(count);
      return row;
   endfunction

   // Directed table; the store is filled to capacity just before row fill_at
   task automatic build_rows();
      // empty list: every command but append is refused
      stim_rows.push_back(typed_row(OP_DUMP,      0, 0, STATUS_EMPTY, 0, 0));
      stim_rows.push_back(typed_row(OP_RM_FRONT,  0, 0, STATUS_EMPTY, 0, 0));
      stim_rows.push_back(typed_row(OP_RM_BACK,   0, 0, STATUS_EMPTY, 0, 0));
      stim_rows.push_back(typed_row(OP_RM_KEY,    0, 0, STATUS_EMPTY, 0, 0));
      stim_rows.push_back(typed_row(OP_INS_FRONT, 1, 0, STATUS_EMPTY, 0, 0));
      stim_rows.push_back(typed_row(OP_INS_BACK,  1, 0, STATUS_EMPTY, 0, 0));
      stim_rows.push_back(typed_row(OP_INS_AFTER, 1, 0, STATUS_EMPTY, 0, 0));
      // build 0, MIN, MAX, -1
      stim_rows.push_back(typed_row(OP_APPEND,    VAL_MIN, 0, STATUS_DONE, 0, 1));
      stim_rows.push_back(typed_row(OP_INS_FRONT, 0,  VAL_MAX, STATUS_DONE, 0, 2));
      stim_rows.push_back(typed_row(OP_INS_BACK,  -1, VAL_MIN, STATUS_DONE, 0, 3));
      stim_rows.push_back(typed_row(OP_INS_AFTER, VAL_MAX, VAL_MIN, STATUS_DONE, 0, 4));
      // key refused: at the back, absent, at the front
      stim_rows.push_back(typed_row(OP_INS_AFTER, 7, -1,    STATUS_KEY, 0, 4));
      stim_rows.push_back(typed_row(OP_INS_AFTER, 7, 12345, STATUS_KEY, 0, 4));
      stim_rows.push_back(typed_row(OP_RM_KEY,    0, 0,     STATUS_KEY, 0, 4));
      stim_rows.push_back(typed_row(OP_RM_KEY,    0, -1,    STATUS_KEY, 0, 4));
      stim_rows.push_back(typed_row(OP_RM_KEY,    0, 555,   STATUS_KEY, 0, 4));
      stim_rows.push_back(plain_row(OP_DUMP, 0, 0));
      stim_rows.push_back(typed_row(OP_RM_KEY, 0, VAL_MAX, STATUS_DONE, VAL_MAX, 3));
      // duplicate keys: first match wins
      stim_rows.push_back(plain_row(OP_APPEND,    VAL_MIN, 0));
      stim_rows.push_back(plain_row(OP_INS_AFTER, 3, VAL_MIN));
      stim_rows.push_back(plain_row(OP_RM_KEY,    0, VAL_MIN));
      stim_rows.push_back(plain_row(OP_RM_FRONT,  0, 0));
      stim_rows.push_back(plain_row(OP_RM_BACK,   0, 0));
      stim_rows.push_back(plain_row(OP_DUMP,      0, 0));
      fill_at = stim_rows.size();
      // full store: list is 3, -1, then -30 .. 31
      stim_rows.push_back(typed_row(OP_APPEND,    99, 0, STATUS_FULL, 0, CAPACITY));
      stim_rows.push_back(typed_row(OP_INS_FRONT, 99, 0, STATUS_FULL, 0, CAPACITY));
      stim_rows.push_back(typed_row(OP_INS_BACK,  99, 0, STATUS_FULL, 0, CAPACITY));
      stim_rows.push_back(typed_row(OP_INS_AFTER, 99, 3, STATUS_FULL, 0, CAPACITY));
      stim_rows.push_back(typed_row(OP_INS_AFTER, 99, 31, STATUS_KEY, 0, CAPACITY));
      stim_rows.push_back(typed_row(OP_RM_KEY,    0, 0, STATUS_DONE, 0, CAPACITY - 1));
      stim_rows.push_back(plain_row(OP_INS_AFTER, 42, 3));
      stim_rows.push_back(plain_row(OP_DUMP, 0, 0));
   endtask

   // Mostly keys that are held, so searches hit; small values give duplicates
   function automatic logic signed [VALUE_W-1:0] pick_key();
      if (shadow_list.size() != 0 && $urandom_range(0, 3) != 0)
         return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
      return $urandom;
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 9) < 3) return int'($urandom_range(0, 4)) - 2;
      return $urandom;
   endfunction

   // Weighted command mix, leaning on removes once the list runs deep
   function automatic logic [OPCODE_W-1:0] pick_opcode();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (shadow_list.size() >= 48 && roll < 45) roll = 55 + roll % 32;
      if (roll < 20) return OP_APPEND;
      if (roll < 30) return OP_INS_FRONT;
      if (roll < 40) return OP_INS_BACK;
      if (roll < 55) return OP_INS_AFTER;
      if (roll < 63) return OP_RM_FRONT;
      if (roll < 71) return OP_RM_BACK;
      if (roll < 87) return OP_RM_KEY;
      return OP_DUMP;
   endfunction

   // Result side: random stall before each item, one long hold on request
   initial begin : result_side
      int unsigned gap;
      rsp_stall = 1'b0;
      forever begin
         if (long_hold_req) begin
            gap = LONG_HOLD;
            long_hold_req = 1'b0;
         end else begin
            gap = quiet_mode ? 0 : $urandom_range(0, 12);
         end
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
         @(negedge clock);
      end
   end

   // Compare each accepted result with the oldest one owed
   always @(posedge clock) begin : result_check
      rsp_type want_rsp;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         results_checked++;
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_data.out_value, 0);
         end else begin
            want_rsp = pending_results.pop_front();
            if (rsp_data.status !== want_rsp.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want_rsp.status));
            if (rsp_data.out_value !== want_rsp.out_value)
               report_mismatch("out_value", rsp_data.out_value, want_rsp.out_value);
            if (rsp_data.last_of_run !== want_rsp.last_of_run)
               report_mismatch("last_of_run", 32'(rsp_data.last_of_run),
                               32'(want_rsp.last_of_run));
            if (rsp_data.entry_count !== want_rsp.entry_count)
               report_mismatch("entry_count", 32'(rsp_data.entry_count),
                               32'(want_rsp.entry_count));
         end
      end
   end

   initial begin : watchdog
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("Timed out with %0d results pending", pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      int      n;
      int      waited;
      rsp_type no_rsp;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      quiet_mode = 1'b0;
      long_hold_req = 1'b0;
      mismatch_count = 0;
      items_accepted = 0;
      results_checked = 0;
      dumps_sent = 0;
      refusals = 0;
      deepest = 0;
      no_rsp = '0;
      build_rows();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table, with a fill to capacity before the full-store rows
      foreach (stim_rows[i]) begin
         if (i == fill_at)
            while (shadow_list.size() < CAPACITY)
               issue_item(make_cmd(OP_APPEND, shadow_list.size() - 32, 0), 1'b0, no_rsp);
         issue_item(stim_rows[i].cmd, stim_rows[i].typed, stim_rows[i].want);
      end
      pause_until_drained();

      // random commands; one quiet stretch carries the long receiver hold
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         quiet_mode = (n % 50) >= 40;
         if (n == 40) long_hold_req = 1'b1;
         if (n == 56) pause_until_drained();
         issue_item(make_cmd(pick_opcode(), pick_value(), pick_key()), 1'b0, no_rsp);
      end
      quiet_mode = 1'b0;
      req_valid <= 1'b0;

      // drain, then watch a while for stray results
      waited = 0;
      while (pending_results.size() != 0 && waited < END_WAIT_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results never arrived", pending_results.size(), 0);

      $display("Ran %0d commands over all eight opcodes (%0d dumps), %0d results checked",
               items_accepted, dumps_sent, results_checked);
      $display("Refused %0d commands; list depth peaked at %0d of %0d entries",
               refusals, deepest, CAPACITY);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
